// ===== hw/rtl/mtdt_pkg.sv =====
// Shared types, codes and constants for the masked tick dispatch table.
`timescale 1ns / 1ps

package mtdt_pkg;

	localparam int MAX_ENTRIES_DEF = 32;
	localparam int ID_WIDTH_DEF    = 8;
	localparam int CMD_W           = 2;
	localparam int STATUS_W        = 3;
	localparam int ID_PORT_W       = 8;
	localparam int MASK_W          = 32;
	localparam int TICK_W          = 32;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK   = 2'd0,
		CMD_ADD    = 2'd1,
		CMD_REMOVE = 2'd2
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_FIRED     = 3'd0,
		ST_NONE      = 3'd1,
		ST_ADDED     = 3'd2,
		ST_FULL      = 3'd3,
		ST_REMOVED   = 3'd4,
		ST_NOT_FOUND = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADD,
		S_TEVAL,
		S_TFIN,
		S_RSCAN,
		S_RSHIFT,
		S_RFIN
	} state_t;

	// Which result the output register loads
	typedef enum logic [1:0] {
		PUSH_PEND,
		PUSH_TICK_END,
		PUSH_ADD,
		PUSH_REM
	} push_sel_t;

	typedef struct packed {
		logic      req_load;
		logic      tick_inc;
		logic      idx_clr;
		logic      idx_inc;
		logic      rd_first;
		logic      rd_next;
		logic      wr_add;
		logic      wr_shift;
		logic      cnt_dec;
		logic      found_set;
		logic      found_clr;
		logic      pend_load;
		logic      pend_clr;
		logic      push;
		push_sel_t push_sel;
	} dp_cmd_t;

	typedef struct packed {
		logic count_zero;
		logic full;
		logic idx_last;
		logic fires;
		logic match;
		logic pend_v;
		logic found;
		logic out_free;
	} dp_status_t;

endpackage

// ===== hw/rtl/mtdt_ctrl.sv =====
// Sequencer for tick scans, appends and removals with gap closing.
`timescale 1ns / 1ps

module mtdt_ctrl
	import mtdt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  logic [1:0] cmd,
	input  dp_status_t st,
	output logic       req_stall,
	output dp_cmd_t    dc
);

	state_t state_q, state_d;
	logic   accept;

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		dc          = '0;
		dc.push_sel = PUSH_PEND;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					dc.req_load = 1'b1;
					case (cmd_t'(cmd))
						CMD_TICK: begin
							dc.tick_inc = 1'b1;
							if (st.count_zero) begin
								state_d = S_TFIN;
							end else begin
								dc.rd_first = 1'b1;
								dc.idx_clr  = 1'b1;
								state_d     = S_TEVAL;
							end
						end
						CMD_ADD: begin
							state_d = S_ADD;
						end
						CMD_REMOVE: begin
							if (st.count_zero) begin
								state_d = S_RFIN;
							end else begin
								dc.rd_first = 1'b1;
								dc.idx_clr  = 1'b1;
								state_d     = S_RSCAN;
							end
						end
						default: begin
							// unused code: drop the transaction
							state_d = S_IDLE;
						end
					endcase
				end
			end
			S_ADD: begin
				if (st.out_free) begin
					dc.push     = 1'b1;
					dc.push_sel = PUSH_ADD;
					dc.wr_add   = !st.full;
					state_d     = S_IDLE;
				end
			end
			S_TEVAL: begin
				// hold the entry while an older hit cannot leave
				if (!(st.fires && st.pend_v && !st.out_free)) begin
					if (st.fires) begin
						dc.pend_load = 1'b1;
						dc.push      = st.pend_v;
						dc.push_sel  = PUSH_PEND;
					end
					if (st.idx_last) begin
						state_d = S_TFIN;
					end else begin
						dc.rd_next = 1'b1;
						dc.idx_inc = 1'b1;
					end
				end
			end
			S_TFIN: begin
				if (st.out_free) begin
					dc.push     = 1'b1;
					dc.push_sel = PUSH_TICK_END;
					dc.pend_clr = 1'b1;
					state_d     = S_IDLE;
				end
			end
			S_RSCAN: begin
				if (st.match) begin
					dc.found_set = 1'b1;
				end
				if (st.idx_last) begin
					state_d = S_RFIN;
				end else begin
					dc.rd_next = 1'b1;
					dc.idx_inc = 1'b1;
					if (st.match) begin
						state_d = S_RSHIFT;
					end
				end
			end
			S_RSHIFT: begin
				// move the entry just read down by one place
				dc.wr_shift = 1'b1;
				if (st.idx_last) begin
					state_d = S_RFIN;
				end else begin
					dc.rd_next = 1'b1;
					dc.idx_inc = 1'b1;
				end
			end
			S_RFIN: begin
				if (st.out_free) begin
					dc.push      = 1'b1;
					dc.push_sel  = PUSH_REM;
					dc.cnt_dec   = st.found;
					dc.found_clr = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== hw/rtl/mtdt_dpath.sv =====
// Entry memory, counters, pending hit and result register.
`timescale 1ns / 1ps

module mtdt_dpath
	import mtdt_pkg::*;
#(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
	parameter int ID_WIDTH    = ID_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [ID_PORT_W-1:0] handler_id,
	input  logic [MASK_W-1:0]    call_mask,
	input  dp_cmd_t              dc,
	output dp_status_t           st,
	input  logic                 rsp_stall,
	output logic                 rsp_valid,
	output logic [STATUS_W-1:0]  status,
	output logic [ID_PORT_W-1:0] fired_id,
	output logic [TICK_W-1:0]    tick_value,
	output logic                 last_result
);

	localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
	localparam int IDX_W   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int ENTRY_W = ID_WIDTH + MASK_W;

	logic [ENTRY_W-1:0]  mem_q [MAX_ENTRIES];
	logic [ENTRY_W-1:0]  rd_data_q;
	logic [IDX_W-1:0]    rd_addr;
	logic                rd_en;
	logic [IDX_W-1:0]    wr_addr;
	logic [ENTRY_W-1:0]  wr_data;
	logic                wr_en;

	logic [TICK_W-1:0]   tick_q;
	logic [CNT_W-1:0]    count_q;
	logic [IDX_W-1:0]    idx_q;
	logic [ID_WIDTH-1:0] req_id_q;
	logic [MASK_W-1:0]   req_mask_q;
	logic                pend_v_q;
	logic [ID_WIDTH-1:0] pend_id_q;
	logic                found_q;

	logic [ID_WIDTH-1:0] rd_id;
	logic [MASK_W-1:0]   rd_mask;
	logic                out_free;

	logic                rsp_valid_q;
	status_t             status_q;
	logic [ID_PORT_W-1:0] fired_id_q;
	logic [TICK_W-1:0]   tick_value_q;
	logic                last_q;

	assign rd_id    = rd_data_q[ENTRY_W-1:MASK_W];
	assign rd_mask  = rd_data_q[MASK_W-1:0];
	assign out_free = !rsp_valid_q || !rsp_stall;

	assign rd_en   = dc.rd_first || dc.rd_next;
	assign rd_addr = dc.rd_first ? '0 : IDX_W'(idx_q + 1'b1);
	assign wr_en   = dc.wr_add || dc.wr_shift;
	assign wr_addr = dc.wr_add ? count_q[IDX_W-1:0] : IDX_W'(idx_q - 1'b1);
	assign wr_data = dc.wr_add ? {req_id_q, req_mask_q} : rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q   <= '0;
			count_q  <= '0;
			idx_q    <= '0;
			pend_v_q <= 1'b0;
			found_q  <= 1'b0;
		end else begin
			if (dc.tick_inc) begin
				tick_q <= tick_q + 1'b1;
			end
			if (dc.wr_add) begin
				count_q <= count_q + 1'b1;
			end else if (dc.cnt_dec) begin
				count_q <= count_q - 1'b1;
			end
			if (dc.idx_clr) begin
				idx_q <= '0;
			end else if (dc.idx_inc) begin
				idx_q <= idx_q + 1'b1;
			end
			if (dc.pend_clr) begin
				pend_v_q <= 1'b0;
			end else if (dc.pend_load) begin
				pend_v_q <= 1'b1;
			end
			if (dc.found_clr) begin
				found_q <= 1'b0;
			end else if (dc.found_set) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dc.req_load) begin
			req_id_q   <= ID_WIDTH'(handler_id);
			req_mask_q <= call_mask;
		end
		if (dc.pend_load) begin
			pend_id_q <= rd_id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (dc.push) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (dc.push) begin
			tick_value_q <= tick_q;
			case (dc.push_sel)
				PUSH_PEND: begin
					status_q   <= ST_FIRED;
					fired_id_q <= ID_PORT_W'(pend_id_q);
					last_q     <= 1'b0;
				end
				PUSH_TICK_END: begin
					status_q   <= pend_v_q ? ST_FIRED : ST_NONE;
					fired_id_q <= pend_v_q ? ID_PORT_W'(pend_id_q) : '0;
					last_q     <= 1'b1;
				end
				PUSH_ADD: begin
					status_q   <= st.full ? ST_FULL : ST_ADDED;
					fired_id_q <= ID_PORT_W'(req_id_q);
					last_q     <= 1'b1;
				end
				PUSH_REM: begin
					status_q   <= found_q ? ST_REMOVED : ST_NOT_FOUND;
					fired_id_q <= ID_PORT_W'(req_id_q);
					last_q     <= 1'b1;
				end
				default: begin
					status_q   <= ST_NONE;
					fired_id_q <= '0;
					last_q     <= 1'b1;
				end
			endcase
		end
	end

	always_comb begin
		st.count_zero = (count_q == '0);
		st.full       = (count_q == CNT_W'(MAX_ENTRIES));
		st.idx_last   = ((CNT_W'(idx_q) + 1'b1) == count_q);
		st.fires      = ((tick_q & rd_mask) == '0);
		st.match      = (rd_id == req_id_q);
		st.pend_v     = pend_v_q;
		st.found      = found_q;
		st.out_free   = out_free;
	end

	assign rsp_valid   = rsp_valid_q;
	assign status      = status_q;
	assign fired_id    = fired_id_q;
	assign tick_value  = tick_value_q;
	assign last_result = last_q;

endmodule

// ===== hw/rtl/masked_tick_dispatch_table.sv =====
// Top level of the masked tick dispatch table.
//
//  channel  dir  handshake              payload
//  req      in   req_valid / req_stall  cmd, handler_id, call_mask
//  rsp      out  rsp_valid / rsp_stall  status, fired_id, tick_value, last_result
//
// A tick accepts the command, then walks the table with the memory read port, one
// entry per cycle unless a hit waits while an older one cannot leave, then closes
// with the final result. A remove scans for the id and moves each later entry down
// by one place; an add is accepted, then answered. rsp_stall can hold each result.
// Reset clears the counter and the entry count; no clearing pass of the memory.
`timescale 1ns / 1ps

module masked_tick_dispatch_table
	import mtdt_pkg::*;
#(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
	parameter int ID_WIDTH    = ID_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  logic [CMD_W-1:0]     cmd,
	input  logic [ID_PORT_W-1:0] handler_id,
	input  logic [MASK_W-1:0]    call_mask,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output logic [STATUS_W-1:0]  status,
	output logic [ID_PORT_W-1:0] fired_id,
	output logic [TICK_W-1:0]    tick_value,
	output logic                 last_result
);

	dp_cmd_t    dc;
	dp_status_t st;

	mtdt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.cmd       (cmd),
		.st        (st),
		.req_stall (req_stall),
		.dc        (dc)
	);

	mtdt_dpath #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.ID_WIDTH    (ID_WIDTH)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.handler_id  (handler_id),
		.call_mask   (call_mask),
		.dc          (dc),
		.st          (st),
		.rsp_stall   (rsp_stall),
		.rsp_valid   (rsp_valid),
		.status      (status),
		.fired_id    (fired_id),
		.tick_value  (tick_value),
		.last_result (last_result)
	);

	// a real command keeps the request side closed in the next cycle
	a_busy_after_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && (cmd != CMD_W'(3)) |=> req_stall)
		else $error("request accepted while a command was in progress");

	a_none_fired: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == ST_NONE) |-> last_result && (fired_id == '0))
		else $error("none-fired result not final or carries an id");

	a_single_final: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status != ST_FIRED) |-> last_result)
		else $error("single-result command not marked final");

	a_hold_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		dc.push && !st.out_free |-> 1'b0)
		else $error("result register overwritten while occupied");

endmodule
